// File: design/byte_budget_lru_cache_policy_assert.svh
// Assertion helpers used by the cache policy module.
`ifndef BYTE_BUDGET_LRU_CACHE_POLICY_ASSERT_SVH
`define BYTE_BUDGET_LRU_CACHE_POLICY_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define BBL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define BBL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bbl_pkg.sv
package bbl_pkg;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_DECIDE,
        ST_FIT,
        ST_EVICT,
        ST_FULL,
        ST_INSERT
    } state_t;

    typedef enum logic [2:0]
    {
        OP_NONE,
        OP_DROP,
        OP_HIT,
        OP_INSERT,
        OP_CLEAR
    } op_t;

    localparam logic [2:0] OUT_HIT     = 3'd0;
    localparam logic [2:0] OUT_MISS    = 3'd1;
    localparam logic [2:0] OUT_STALE   = 3'd2;
    localparam logic [2:0] OUT_BYPASS  = 3'd3;
    localparam logic [2:0] OUT_CLEARED = 3'd4;

    localparam logic [31:0] CAPACITY_RESET = 32'd16777216;
    localparam logic [4:0]  EVICT_MAX      = 5'd31;

    typedef struct packed
    {
        logic [31:0] key;
        logic [31:0] stamp;
        logic [31:0] bytes;
    } entry_t;

endpackage

// File: design/bbl_store.sv
module bbl_store
    import bbl_pkg::*;
#(
    parameter int NUM_ENTRIES = 16,
    localparam int IW = $clog2(NUM_ENTRIES)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [IW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [IW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [NUM_ENTRIES];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/bbl_order.sv
module bbl_order
    import bbl_pkg::*;
#(
    parameter int NUM_ENTRIES = 16,
    localparam int IW = $clog2(NUM_ENTRIES),
    localparam int CW = $clog2(NUM_ENTRIES + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  op_t                    op,
    input  logic [IW-1:0]          op_idx,
    output logic [NUM_ENTRIES-1:0] valid_vec,
    output logic [CW-1:0]          count,
    output logic [IW-1:0]          oldest
);

    // Per-entry rank plus the inverse list, so the oldest entry sits at a fixed place.
    logic [NUM_ENTRIES-1:0] valid_reg, valid_next;
    logic [IW-1:0]          rank_reg  [NUM_ENTRIES];
    logic [IW-1:0]          rank_next [NUM_ENTRIES];
    logic [IW-1:0]          order_reg [NUM_ENTRIES];
    logic [IW-1:0]          order_next[NUM_ENTRIES];
    logic [CW-1:0]          count_reg, count_next;
    logic [IW-1:0]          r;
    logic [CW-1:0]          count_m1;

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        order_next = order_reg;
        count_next = count_reg;
        r          = rank_reg[op_idx];
        count_m1   = count_reg - CW'(1);
        unique case (op) inside
            OP_DROP, OP_HIT:
            begin
                for (int i = 0; i < NUM_ENTRIES; i++)
                begin
                    if (valid_reg[i] && rank_reg[i] > r)
                    begin
                        rank_next[i] = rank_reg[i] - IW'(1);
                    end
                end
                for (int p = 0; p < NUM_ENTRIES - 1; p++)
                begin
                    if (IW'(p) >= r)
                    begin
                        order_next[p] = order_reg[p + 1];
                    end
                end
                if (op == OP_DROP)
                begin
                    valid_next[op_idx] = 1'b0;
                    rank_next[op_idx]  = '0;
                    count_next         = count_m1;
                end
                else
                begin
                    rank_next[op_idx]            = count_m1[IW-1:0];
                    order_next[count_m1[IW-1:0]] = op_idx;
                end
            end
            OP_INSERT:
            begin
                valid_next[op_idx]            = 1'b1;
                rank_next[op_idx]             = count_reg[IW-1:0];
                order_next[count_reg[IW-1:0]] = op_idx;
                count_next                    = count_reg + CW'(1);
            end
            OP_CLEAR:
            begin
                valid_next = '0;
                for (int i = 0; i < NUM_ENTRIES; i++)
                begin
                    rank_next[i] = '0;
                end
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                rank_reg[i]  <= '0;
                order_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
            order_reg <= order_next;
        end
    end

    assign valid_vec = valid_reg;
    assign count     = count_reg;
    assign oldest    = order_reg[0];

endmodule

// File: design/byte_budget_lru_cache_policy.sv
// A clear passes through the clear state alone. An access scans the entry memory one entry
// a cycle and then decides; a hit or bypass ends there. A miss then fits and inserts, with an
// evict and fit round per byte-budget eviction and the full state for a full-table eviction.
// Throughput is one request at a time; busy stays high until the result is formed.
// Each result is shown for one cycle on done; the receiver cannot stall it.
// Reset (rst_n low, asynchronous) empties the table and restores the default capacity.
`include "byte_budget_lru_cache_policy_assert.svh"

module byte_budget_lru_cache_policy
    import bbl_pkg::*;
#(
    parameter int NUM_ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        capacity_we,
    input  logic [31:0] capacity_wdata,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [31:0] object_key,
    input  logic [31:0] mod_stamp,
    input  logic [31:0] object_bytes,
    output logic        done,
    output logic [2:0]  outcome,
    output logic [4:0]  evicted_count,
    output logic [31:0] used_bytes
);

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam int CW = $clog2(NUM_ENTRIES + 1);

    // Control state.
    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg;
    logic          pipe_vld_reg;
    logic [IW-1:0] pipe_idx_reg;
    logic          found_reg;
    logic          stamp_eq_reg;
    logic          free_found_reg;
    logic          stale_reg;
    logic [4:0]    evicted_reg;
    logic [31:0]   total_reg;
    logic [31:0]   cap_reg;
    logic          done_reg;

    // Payload held for the request in flight.
    logic [IW-1:0] match_idx_reg;
    logic [31:0]   match_bytes_reg;
    logic [IW-1:0] free_idx_reg;
    logic [31:0]   key_reg;
    logic [31:0]   stamp_reg;
    logic [31:0]   size_reg;
    logic [2:0]    outcome_reg;
    logic [4:0]    evicted_out_reg;
    logic [31:0]   used_reg;

    // Memory and recency unit hookup.
    logic                   mem_we;
    logic [IW-1:0]          mem_raddr;
    entry_t                 mem_wdata;
    entry_t                 mem_rdata;
    op_t                    lru_op;
    logic [IW-1:0]          lru_idx;
    logic [NUM_ENTRIES-1:0] lru_valid;
    logic [CW-1:0]          lru_count;
    logic [IW-1:0]          lru_oldest;

    // Result formed this cycle.
    logic        res_load;
    logic [2:0]  res_outcome;
    logic [4:0]  res_evicted;
    logic [31:0] res_used;

    logic        over_budget;
    logic        scan_live;
    logic [31:0] total_less_match;

    bbl_store #(.NUM_ENTRIES(NUM_ENTRIES)) u_store
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (free_idx_reg),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bbl_order #(.NUM_ENTRIES(NUM_ENTRIES)) u_order
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (lru_op),
        .op_idx    (lru_idx),
        .valid_vec (lru_valid),
        .count     (lru_count),
        .oldest    (lru_oldest)
    );

    // The object fits only if the current total plus its size stays within capacity.
    assign over_budget      = ({1'b0, total_reg} + {1'b0, size_reg}) > {1'b0, cap_reg};
    assign scan_live        = lru_valid[pipe_idx_reg];
    assign total_less_match = total_reg - match_bytes_reg;
    assign mem_wdata        = '{key: key_reg, stamp: stamp_reg, bytes: size_reg};

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = mode ? ST_CLEAR : ST_SCAN;
                end
            end
            ST_CLEAR:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (cnt_reg == CW'(NUM_ENTRIES))
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if ((found_reg && stamp_eq_reg) || (size_reg > cap_reg))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FIT;
                end
            end
            ST_FIT:
            begin
                if (over_budget && lru_count != '0)
                begin
                    state_next = ST_EVICT;
                end
                else if (!free_found_reg)
                begin
                    state_next = ST_FULL;
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_EVICT:
            begin
                state_next = ST_FIT;
            end
            ST_FULL:
            begin
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output and command logic for the memory, the recency unit and the result.
    always_comb
    begin
        mem_we      = 1'b0;
        mem_raddr   = lru_oldest;
        lru_op      = OP_NONE;
        lru_idx     = match_idx_reg;
        res_load    = 1'b0;
        res_outcome = OUT_HIT;
        res_evicted = '0;
        res_used    = total_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_CLEAR:
            begin
                lru_op      = OP_CLEAR;
                res_load    = 1'b1;
                res_outcome = OUT_CLEARED;
                res_used    = '0;
            end
            ST_SCAN:
            begin
                mem_raddr = cnt_reg[IW-1:0];
            end
            ST_DECIDE:
            begin
                if (found_reg && stamp_eq_reg)
                begin
                    lru_op   = OP_HIT;
                    res_load = 1'b1;
                end
                else
                begin
                    if (found_reg)
                    begin
                        lru_op   = OP_DROP;
                        res_used = total_less_match;
                    end
                    if (size_reg > cap_reg)
                    begin
                        res_load    = 1'b1;
                        res_outcome = OUT_BYPASS;
                    end
                end
            end
            ST_FIT:
            begin
                // The read of the oldest entry is issued here in case it must go.
            end
            ST_EVICT, ST_FULL:
            begin
                lru_op  = OP_DROP;
                lru_idx = lru_oldest;
            end
            ST_INSERT:
            begin
                mem_we      = 1'b1;
                lru_op      = OP_INSERT;
                lru_idx     = free_idx_reg;
                res_load    = 1'b1;
                res_outcome = stale_reg ? OUT_STALE : OUT_MISS;
                res_evicted = evicted_reg;
                res_used    = total_reg + size_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            pipe_vld_reg   <= 1'b0;
            found_reg      <= 1'b0;
            stamp_eq_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            stale_reg      <= 1'b0;
            evicted_reg    <= '0;
            total_reg      <= '0;
            cap_reg        <= CAPACITY_RESET;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= res_load;
            if (capacity_we)
            begin
                cap_reg <= capacity_wdata;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg        <= '0;
                    pipe_vld_reg   <= 1'b0;
                    found_reg      <= 1'b0;
                    free_found_reg <= 1'b0;
                    stale_reg      <= 1'b0;
                    evicted_reg    <= '0;
                end
                ST_CLEAR:
                begin
                    total_reg <= '0;
                end
                ST_SCAN:
                begin
                    // Reads are issued one entry ahead of the compare.
                    if (cnt_reg < CW'(NUM_ENTRIES))
                    begin
                        cnt_reg      <= cnt_reg + CW'(1);
                        pipe_vld_reg <= 1'b1;
                    end
                    else
                    begin
                        pipe_vld_reg <= 1'b0;
                    end
                    if (pipe_vld_reg)
                    begin
                        if (scan_live && mem_rdata.key == key_reg && !found_reg)
                        begin
                            found_reg    <= 1'b1;
                            stamp_eq_reg <= (mem_rdata.stamp == stamp_reg);
                        end
                        if (!scan_live && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                        end
                    end
                end
                ST_DECIDE:
                begin
                    if (found_reg && !stamp_eq_reg)
                    begin
                        total_reg      <= total_less_match;
                        stale_reg      <= 1'b1;
                        free_found_reg <= 1'b1;
                    end
                end
                ST_EVICT, ST_FULL:
                begin
                    total_reg      <= total_reg - mem_rdata.bytes;
                    free_found_reg <= 1'b1;
                    if (evicted_reg != EVICT_MAX)
                    begin
                        evicted_reg <= evicted_reg + 5'd1;
                    end
                end
                ST_INSERT:
                begin
                    total_reg <= total_reg + size_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            key_reg   <= object_key;
            stamp_reg <= mod_stamp;
            size_reg  <= object_bytes;
        end
        if (state_reg == ST_SCAN)
        begin
            pipe_idx_reg <= cnt_reg[IW-1:0];
            if (pipe_vld_reg)
            begin
                if (scan_live && mem_rdata.key == key_reg && !found_reg)
                begin
                    match_idx_reg   <= pipe_idx_reg;
                    match_bytes_reg <= mem_rdata.bytes;
                end
                if (!scan_live && !free_found_reg)
                begin
                    free_idx_reg <= pipe_idx_reg;
                end
            end
        end
        // A dropped entry frees its slot; keep the lowest free index.
        if (state_reg == ST_DECIDE && found_reg && !stamp_eq_reg)
        begin
            if (!free_found_reg || match_idx_reg < free_idx_reg)
            begin
                free_idx_reg <= match_idx_reg;
            end
        end
        if (state_reg == ST_EVICT)
        begin
            if (!free_found_reg || lru_oldest < free_idx_reg)
            begin
                free_idx_reg <= lru_oldest;
            end
        end
        if (state_reg == ST_FULL)
        begin
            free_idx_reg <= lru_oldest;
        end
        if (res_load)
        begin
            outcome_reg     <= res_outcome;
            evicted_out_reg <= res_evicted;
            used_reg        <= res_used;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign outcome       = outcome_reg;
    assign evicted_count = evicted_out_reg;
    assign used_bytes    = used_reg;

    `BBL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
    `BBL_ASSERT_IMP(a_count_bound, 1'b1, lru_count <= CW'(NUM_ENTRIES), "entry count overflow")
    `BBL_ASSERT_IMP(a_hit_no_evict, done && outcome == OUT_HIT, evicted_count == '0, "hit evicted")
    `BBL_ASSERT_IMP(a_insert_fits, done && (outcome == OUT_MISS || outcome == OUT_STALE), used_bytes <= cap_reg, "insert over budget")

endmodule
